### rtl/core/dds_pkg.sv
// Shared types and constants for the differential drive supervisor.
// Holds op codes, register indexes, reset values and controller/datapath links.
// No dependencies.
package dds_pkg;

    localparam int DUTY_BITS_DEF = 10;
    localparam int FRAC_BITS_DEF = 10;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 10;

    typedef enum logic [1:0] {
        OP_DRIVE = 2'd0,
        OP_STOP  = 2'd1,
        OP_TICK  = 2'd2,
        OP_DIST  = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SPEED_LIMIT    = 3'd0,
        CFG_AVOID_DISTANCE = 3'd1,
        CFG_AVOID_ENABLE   = 3'd2,
        CFG_DEADMAN_MS     = 3'd3,
        CFG_AVOID_INTERVAL = 3'd4
    } t_cfg_idx;

    localparam logic [9:0] SPEED_LIMIT_RST  = 10'd461;
    localparam logic [9:0] SPEED_LIMIT_MIN  = 10'd154;
    localparam logic [9:0] SPEED_LIMIT_MAX  = 10'd768;
    localparam logic [6:0] AVOID_DIST_RST   = 7'd25;
    localparam logic [6:0] AVOID_DIST_MIN   = 7'd15;
    localparam logic [6:0] AVOID_DIST_MAX   = 7'd80;
    localparam logic [9:0] DEADMAN_RST      = 10'd650;
    localparam logic [9:0] DEADMAN_MIN      = 10'd1;
    localparam logic [9:0] DEADMAN_MAX      = 10'd1000;
    localparam logic [7:0] AVOID_IVAL_RST   = 8'd180;
    localparam logic [7:0] AVOID_IVAL_MIN   = 8'd1;

    typedef struct packed {
        logic load_in;
        logic decide;
        logic mul;
        logic commit;
        logic load_out;
    } t_dds_cmd;

    typedef struct packed {
        logic out_free;
    } t_dds_status;

endpackage

### rtl/core/dds_ctrl.sv
// Sequencing controller for the differential drive supervisor.
// Steps one request through decide, multiply, scale and output load.
// Depends on dds_pkg.
module dds_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  dds_pkg::t_dds_status  i_status,
    output dds_pkg::t_dds_cmd     o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECIDE = 5'b00010,
        S_MUL    = 5'b00100,
        S_SCALE  = 5'b01000,
        S_HOLD   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load_in = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.commit = 1'b1;
                n_state      = S_HOLD;
            end
            S_HOLD: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

### rtl/core/dds_dp.sv
// Datapath of the differential drive supervisor: registers, timers, mixer,
// duty scaling and the output register. Driven by dds_ctrl commands.
// Depends on dds_pkg.
module dds_dp #(
    parameter int DUTY_BITS = dds_pkg::DUTY_BITS_DEF,
    parameter int FRAC_BITS = dds_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  dds_pkg::t_dds_cmd                  i_cmd,
    output dds_pkg::t_dds_status               o_status,
    input  logic                               i_cfg_we,
    input  logic [dds_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [dds_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic [1:0]                         i_op,
    input  logic signed [11:0]                 i_throttle,
    input  logic signed [11:0]                 i_steering,
    input  logic [8:0]                         i_distance_cm,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [DUTY_BITS-1:0]               o_left_duty,
    output logic                               o_left_in_a,
    output logic                               o_left_in_b,
    output logic [DUTY_BITS-1:0]               o_right_duty,
    output logic                               o_right_in_a,
    output logic                               o_right_in_b,
    output logic                               o_drive_active,
    output logic [8:0]                         o_last_distance
);

    localparam int ONE        = 1 << FRAC_BITS;
    localparam int VW         = (FRAC_BITS + 2 > 12) ? FRAC_BITS + 2 : 12;
    localparam int SW         = VW + 1;
    localparam int MW         = FRAC_BITS + 1;
    localparam int PW         = MW + 10;
    localparam int QW         = PW + DUTY_BITS + 1;
    localparam int DW         = DUTY_BITS + 1;
    localparam int ACT_TH     = ONE / 100;
    localparam int AVOID_TMAG = ((22 << FRAC_BITS) + 50) / 100;
    localparam int AVOID_SMAG = ((36 << FRAC_BITS) + 50) / 100;

    localparam logic signed [SW-1:0] ONE_P  = SW'(ONE);
    localparam logic signed [SW-1:0] ONE_N  = SW'(-ONE);
    localparam logic signed [SW-1:0] ACT_P  = SW'(ACT_TH);
    localparam logic signed [SW-1:0] ACT_N  = SW'(-ACT_TH);
    localparam logic signed [SW-1:0] AVT_S  = SW'(-AVOID_TMAG);
    localparam logic signed [SW-1:0] AVS_S  = SW'(AVOID_SMAG);
    localparam logic [DW-1:0]        DMAX   = DW'((1 << DUTY_BITS) - 1);
    localparam logic [QW-1:0]        RND    = QW'(1) << (FRAC_BITS + 9);

    function automatic logic signed [SW-1:0] sat_one(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] r;
        r = v;
        if (v > ONE_P) begin
            r = ONE_P;
        end else if (v < ONE_N) begin
            r = ONE_N;
        end
        return r;
    endfunction

    function automatic logic [DUTY_BITS-1:0] scale_duty(input logic [PW-1:0] p);
        logic [QW-1:0] q;
        logic [DW-1:0] d;
        q = (QW'(p) << DUTY_BITS) - QW'(p);
        q = q + RND;
        d = q[FRAC_BITS+10 +: DW];
        if (d > DMAX) begin
            d = DMAX;
        end
        return d[DUTY_BITS-1:0];
    endfunction

    // configuration and state
    logic [9:0]            r_speed_limit;
    logic [6:0]            r_avoid_dist;
    logic                  r_avoid_en;
    logic [9:0]            r_deadman;
    logic [7:0]            r_avoid_ival;
    logic [DUTY_BITS-1:0]  r_left_duty;
    logic [DUTY_BITS-1:0]  r_right_duty;
    logic [1:0]            r_left_pins;
    logic [1:0]            r_right_pins;
    logic                  r_active;
    logic [9:0]            r_ms_drive;
    logic [7:0]            r_ms_avoid;
    logic [8:0]            r_distance;
    logic                  r_out_valid;

    // request and intermediate payload
    dds_pkg::t_op          r_op;
    logic signed [11:0]    r_throttle;
    logic signed [11:0]    r_steering;
    logic [8:0]            r_dist_in;
    logic                  r_do_drive;
    logic                  r_act_new;
    logic [MW-1:0]         r_mag_l;
    logic [MW-1:0]         r_mag_r;
    logic                  r_pos_l;
    logic                  r_pos_r;
    logic [PW-1:0]         r_prod_l;
    logic [PW-1:0]         r_prod_r;

    logic signed [SW-1:0]  t_sel;
    logic signed [SW-1:0]  s_sel;
    logic signed [SW-1:0]  ts;
    logic signed [SW-1:0]  ss;
    logic signed [SW-1:0]  mix_l;
    logic signed [SW-1:0]  mix_r;
    logic signed [SW-1:0]  neg_l;
    logic signed [SW-1:0]  neg_r;
    logic                  act_new;
    logic                  avoid_go;
    logic                  avoid_hit;
    logic                  do_drive;
    logic [9:0]            ms_drive_inc;
    logic [7:0]            ms_avoid_inc;
    logic [DUTY_BITS-1:0]  duty_l;
    logic [DUTY_BITS-1:0]  duty_r;
    logic [9:0]            cfg_v10;
    logic [6:0]            cfg_v7;
    logic [7:0]            cfg_v8;

    always_comb begin
        if (r_op == dds_pkg::OP_DRIVE) begin
            t_sel = {{(SW-12){r_throttle[11]}}, r_throttle};
            s_sel = {{(SW-12){r_steering[11]}}, r_steering};
        end else begin
            t_sel = AVT_S;
            s_sel = AVS_S;
        end
        ts      = sat_one(t_sel);
        ss      = sat_one(s_sel);
        mix_l   = sat_one(ts + ss);
        mix_r   = sat_one(ts - ss);
        neg_l   = -mix_l;
        neg_r   = -mix_r;
        act_new = (ts > ACT_P) || (ts < ACT_N) || (ss > ACT_P) || (ss < ACT_N);
    end

    assign avoid_go  = r_avoid_en && (r_ms_avoid >= r_avoid_ival);
    assign avoid_hit = (r_dist_in != 9'd0) && (r_dist_in < {2'b00, r_avoid_dist});
    assign do_drive  = (r_op == dds_pkg::OP_DRIVE) ||
                       ((r_op == dds_pkg::OP_DIST) && avoid_go && avoid_hit);

    assign ms_drive_inc = (r_ms_drive == 10'h3FF) ? r_ms_drive : r_ms_drive + 10'd1;
    assign ms_avoid_inc = (r_ms_avoid == 8'hFF) ? r_ms_avoid : r_ms_avoid + 8'd1;

    assign duty_l = scale_duty(r_prod_l);
    assign duty_r = scale_duty(r_prod_r);

    assign cfg_v10 = i_cfg_data[9:0];
    assign cfg_v7  = i_cfg_data[6:0];
    assign cfg_v8  = i_cfg_data[7:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_limit <= dds_pkg::SPEED_LIMIT_RST;
            r_avoid_dist  <= dds_pkg::AVOID_DIST_RST;
            r_avoid_en    <= 1'b0;
            r_deadman     <= dds_pkg::DEADMAN_RST;
            r_avoid_ival  <= dds_pkg::AVOID_IVAL_RST;
            r_left_duty   <= '0;
            r_right_duty  <= '0;
            r_left_pins   <= 2'b00;
            r_right_pins  <= 2'b00;
            r_active      <= 1'b0;
            r_ms_drive    <= '0;
            r_ms_avoid    <= '0;
            r_distance    <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.load_out || (r_out_valid && i_out_stall);
            if (i_cfg_we) begin
                case (dds_pkg::t_cfg_idx'(i_cfg_index))
                    dds_pkg::CFG_SPEED_LIMIT: begin
                        if (cfg_v10 < dds_pkg::SPEED_LIMIT_MIN) begin
                            r_speed_limit <= dds_pkg::SPEED_LIMIT_MIN;
                        end else if (cfg_v10 > dds_pkg::SPEED_LIMIT_MAX) begin
                            r_speed_limit <= dds_pkg::SPEED_LIMIT_MAX;
                        end else begin
                            r_speed_limit <= cfg_v10;
                        end
                    end
                    dds_pkg::CFG_AVOID_DISTANCE: begin
                        if (cfg_v7 < dds_pkg::AVOID_DIST_MIN) begin
                            r_avoid_dist <= dds_pkg::AVOID_DIST_MIN;
                        end else if (cfg_v7 > dds_pkg::AVOID_DIST_MAX) begin
                            r_avoid_dist <= dds_pkg::AVOID_DIST_MAX;
                        end else begin
                            r_avoid_dist <= cfg_v7;
                        end
                    end
                    dds_pkg::CFG_AVOID_ENABLE: begin
                        r_avoid_en   <= i_cfg_data[0];
                        r_left_duty  <= '0;
                        r_right_duty <= '0;
                        r_left_pins  <= 2'b00;
                        r_right_pins <= 2'b00;
                        r_active     <= 1'b0;
                    end
                    dds_pkg::CFG_DEADMAN_MS: begin
                        if (cfg_v10 < dds_pkg::DEADMAN_MIN) begin
                            r_deadman <= dds_pkg::DEADMAN_MIN;
                        end else if (cfg_v10 > dds_pkg::DEADMAN_MAX) begin
                            r_deadman <= dds_pkg::DEADMAN_MAX;
                        end else begin
                            r_deadman <= cfg_v10;
                        end
                    end
                    dds_pkg::CFG_AVOID_INTERVAL: begin
                        if (cfg_v8 < dds_pkg::AVOID_IVAL_MIN) begin
                            r_avoid_ival <= dds_pkg::AVOID_IVAL_MIN;
                        end else begin
                            r_avoid_ival <= cfg_v8;
                        end
                    end
                    default: begin
                    end
                endcase
            end else if (i_cmd.decide) begin
                case (r_op)
                    dds_pkg::OP_STOP: begin
                        r_left_duty  <= '0;
                        r_right_duty <= '0;
                        r_left_pins  <= 2'b00;
                        r_right_pins <= 2'b00;
                        r_active     <= 1'b0;
                    end
                    dds_pkg::OP_TICK: begin
                        r_ms_drive <= ms_drive_inc;
                        r_ms_avoid <= ms_avoid_inc;
                        if (r_active && (ms_drive_inc > r_deadman)) begin
                            r_left_duty  <= '0;
                            r_right_duty <= '0;
                            r_left_pins  <= 2'b00;
                            r_right_pins <= 2'b00;
                            r_active     <= 1'b0;
                        end
                    end
                    dds_pkg::OP_DIST: begin
                        r_distance <= r_dist_in;
                        if (avoid_go) begin
                            r_ms_avoid <= '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end else if (i_cmd.commit && r_do_drive) begin
                r_left_duty  <= duty_l;
                r_right_duty <= duty_r;
                r_left_pins  <= (duty_l == '0) ? 2'b00 : (r_pos_l ? 2'b01 : 2'b10);
                r_right_pins <= (duty_r == '0) ? 2'b00 : (r_pos_r ? 2'b01 : 2'b10);
                r_active     <= r_act_new;
                r_ms_drive   <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op       <= dds_pkg::t_op'(i_op);
            r_throttle <= i_throttle;
            r_steering <= i_steering;
            r_dist_in  <= i_distance_cm;
        end
        if (i_cmd.decide) begin
            r_do_drive <= do_drive;
            r_act_new  <= act_new;
            r_mag_l    <= mix_l[SW-1] ? neg_l[MW-1:0] : mix_l[MW-1:0];
            r_mag_r    <= mix_r[SW-1] ? neg_r[MW-1:0] : mix_r[MW-1:0];
            r_pos_l    <= !mix_l[SW-1] && (mix_l != '0);
            r_pos_r    <= !mix_r[SW-1] && (mix_r != '0);
        end
        if (i_cmd.mul) begin
            r_prod_l <= PW'(r_mag_l) * PW'(r_speed_limit);
            r_prod_r <= PW'(r_mag_r) * PW'(r_speed_limit);
        end
        if (i_cmd.load_out) begin
            o_left_duty     <= r_left_duty;
            o_left_in_a     <= r_left_pins[0];
            o_left_in_b     <= r_left_pins[1];
            o_right_duty    <= r_right_duty;
            o_right_in_a    <= r_right_pins[0];
            o_right_in_b    <= r_right_pins[1];
            o_drive_active  <= r_active;
            o_last_distance <= r_distance;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status.out_free = !r_out_valid || !i_out_stall;

endmodule

### rtl/core/differential_drive_supervisor_top.sv
// Top level of the differential drive supervisor for two H-bridge motors.
// Joins dds_ctrl and dds_dp; depends on dds_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one request: drive,
//   stop, 1 ms tick or distance sample, selected by i_op. Each request
//   yields exactly one result on the output channel (o_out_valid /
//   i_out_stall) giving duties, bridge pin levels, drive_active and the
//   last distance after the request.
//   Configuration writes use i_cfg_we, i_cfg_index, i_cfg_data; values are
//   clamped into range and take effect at once. Write only while idle.
//   An accepted request passes the decide, multiply, scale and output-load
//   steps of the controller before o_out_valid rises; a new request is
//   accepted only in idle, and the next one is taken while a result waits.
//   A stalled result holds in the output register; the controller then
//   waits before loading the following one, which holds o_in_stall high.
//   Reset (synchronous, active low) stops both motors, clears the timers
//   and distance, and restores register defaults.
module differential_drive_supervisor_top #(
    parameter int DUTY_BITS = dds_pkg::DUTY_BITS_DEF,
    parameter int FRAC_BITS = dds_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [dds_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [dds_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_op,
    input  logic signed [11:0]                 i_throttle,
    input  logic signed [11:0]                 i_steering,
    input  logic [8:0]                         i_distance_cm,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [DUTY_BITS-1:0]               o_left_duty,
    output logic                               o_left_in_a,
    output logic                               o_left_in_b,
    output logic [DUTY_BITS-1:0]               o_right_duty,
    output logic                               o_right_in_a,
    output logic                               o_right_in_b,
    output logic                               o_drive_active,
    output logic [8:0]                         o_last_distance
);

    dds_pkg::t_dds_cmd    cmd;
    dds_pkg::t_dds_status status;

    dds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    dds_dp #(
        .DUTY_BITS (DUTY_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_op            (i_op),
        .i_throttle      (i_throttle),
        .i_steering      (i_steering),
        .i_distance_cm   (i_distance_cm),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_left_duty     (o_left_duty),
        .o_left_in_a     (o_left_in_a),
        .o_left_in_b     (o_left_in_b),
        .o_right_duty    (o_right_duty),
        .o_right_in_a    (o_right_in_a),
        .o_right_in_b    (o_right_in_b),
        .o_drive_active  (o_drive_active),
        .o_last_distance (o_last_distance)
    );

endmodule
